// ===== src/bvl_pkg.sv =====
// Shared constants, stage map and types for the blood viscosity pipeline.
package bvl_pkg;

    // iteration counts of the pipelined units
    localparam int DivSteps    = 28;
    localparam int LogSteps    = 24;
    localparam int SeriesTerms = 12;

    // stage map: input, prep, divide/log2 steps, C, Y, X, series, product, shift, clamp
    localparam int StIter    = 2;
    localparam int StC       = StIter + DivSteps;
    localparam int StY       = StC + 1;
    localparam int StX       = StC + 2;
    localparam int StSer     = StC + 3;
    localparam int StP       = StSer + 2 * SeriesTerms;
    localparam int StS       = StP + 1;
    localparam int StO       = StP + 2;
    localparam int NumStages = StO + 1;

    // fixed-point constants
    localparam logic [28:0] KaQ32  = 29'd376736742;
    localparam logic [28:0] KbQ24  = 29'd353021267;
    localparam logic [24:0] KcQ32  = 25'd21431887;
    localparam logic [29:0] Ln2Q30 = 30'd744261118;
    localparam logic signed [17:0] FracMinS = 18'sd16384;
    localparam logic signed [17:0] FracMaxS = 18'sd65536;
    localparam logic [16:0] FracMin = 17'd16384;
    localparam logic [16:0] FracMax = 17'd65536;
    localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

    // register indexes
    typedef enum logic [1:0] {
        REG_SCALE   = 2'd0,
        REG_PROTEIN = 2'd1,
        REG_FLOOR   = 2'd2,
        REG_CEILING = 2'd3
    } cfg_index_t;

    // register file contents
    typedef struct packed {
        logic [31:0] scale;
        logic [23:0] protein;
        logic [31:0] vfloor;
        logic [31:0] vceil;
    } cfg_t;

endpackage

// ===== src/bvl_channels.sv =====
// Valid/ready channel interfaces for the input and result words.
interface bvl_in_if;
    logic                valid;
    logic                ready;
    logic signed [17:0]  volume_fraction;
    logic        [31:0]  shear_rate;

    modport source (output valid, volume_fraction, shear_rate, input ready);
    modport sink   (input valid, volume_fraction, shear_rate, output ready);
endinterface

interface bvl_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] viscosity;

    modport source (output valid, viscosity, input ready);
    modport sink   (input valid, viscosity, output ready);
endinterface

// ===== src/bvl_datapath.sv =====
// Pipelined datapath: log2, divide, exp2 series, scaling and clamping.
module bvl_datapath (
    input  logic                              clk,
    input  logic [bvl_pkg::NumStages-1:0]     en,
    input  bvl_pkg::cfg_t                     cfg,
    input  logic signed [17:0]                volume_fraction,
    input  logic [31:0]                       shear_rate,
    output logic [31:0]                       viscosity
);
    import bvl_pkg::*;

    typedef struct packed {
        logic [27:0] a;
        logic [23:0] g;
        logic [29:0] den;
        logic [52:0] rem;
        logic [27:0] quo;
        logic [4:0]  lead;
        logic [31:0] mant;
        logic [23:0] lfrac;
    } iter_t;

    typedef struct packed {
        logic [29:0]        x;
        logic signed [7:0]  n;
        logic [30:0]        term;
        logic [30:0]        tx;
        logic [31:0]        sum;
    } ser_t;

    // stage 0: clamp fraction, scale to percent, floor the rate
    logic [16:0] frac_c;
    logic [22:0] h_next;
    logic [31:0] rate_next;
    logic [22:0] h_reg;
    logic [31:0] rate_reg;

    always_comb
    begin
        if (volume_fraction < FracMinS)
            frac_c = FracMin;
        else if (volume_fraction > FracMaxS)
            frac_c = FracMax;
        else
            frac_c = volume_fraction[16:0];
    end

    assign h_next    = 23'(frac_c) * 23'd100;
    assign rate_next = (shear_rate == 32'd0) ? 32'd1 : shear_rate;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            h_reg    <= h_next;
            rate_reg <= rate_next;
        end
    end

    // stage 1: products of H, numerator, rate normalization
    logic [4:0]  lead;
    iter_t       prep;
    iter_t       it_reg [DivSteps+1];

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (rate_reg[i])
                lead = 5'(i);
        end
    end

    always_comb
    begin
        prep.a     = 28'((52'(KaQ32) * 52'(h_reg)) >> 24);
        prep.g     = 24'((48'(KcQ32) * 48'(h_reg)) >> 24);
        prep.den   = 30'((46'(h_reg) * 46'(h_reg)) >> 16);
        prep.rem   = 53'(KbQ24) * 53'(cfg.protein);
        prep.quo   = '0;
        prep.lead  = lead;
        prep.mant  = rate_reg << (5'd31 - lead);
        prep.lfrac = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
            it_reg[0] <= prep;
    end

    // divide steps (one quotient bit each) alongside log2 squaring steps
    for (genvar j = 0; j < DivSteps; j++)
    begin : g_iter
        localparam int Bit = DivSteps - 1 - j;
        logic [57:0] dsh;
        logic        take;
        logic [31:0] mant_next;
        logic [23:0] lfrac_next;
        iter_t       it_next;

        assign dsh  = 58'(it_reg[j].den) << Bit;
        assign take = 58'(it_reg[j].rem) >= dsh;

        if (j < LogSteps)
        begin : g_log
            logic [63:0] sq;
            assign sq         = 64'(it_reg[j].mant) * 64'(it_reg[j].mant);
            assign mant_next  = sq[63] ? sq[63:32] : sq[62:31];
            assign lfrac_next = {it_reg[j].lfrac[22:0], sq[63]};
        end
        else
        begin : g_pass
            assign mant_next  = it_reg[j].mant;
            assign lfrac_next = it_reg[j].lfrac;
        end

        always_comb
        begin
            it_next       = it_reg[j];
            it_next.mant  = mant_next;
            it_next.lfrac = lfrac_next;
            if (take)
            begin
                it_next.rem      = 53'(58'(it_reg[j].rem) - dsh);
                it_next.quo[Bit] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[StIter+j])
                it_reg[j+1] <= it_next;
        end
    end

    // stage C: rate term magnitude and A+B
    logic signed [29:0] lval;
    logic        [28:0] lmag;
    logic        [27:0] cmag_next;
    logic        [28:0] ab_reg;
    logic        [27:0] cmag_reg;
    logic               lneg_reg;

    assign lval      = $signed({1'b0, it_reg[DivSteps].lead, it_reg[DivSteps].lfrac})
                       - 30'sd268435456;
    assign lmag      = lval[29] ? 29'(-lval) : 29'(lval);
    assign cmag_next = 28'((53'(it_reg[DivSteps].g) * 53'(lmag)) >> 24);

    always_ff @(posedge clk)
    begin
        if (en[StC])
        begin
            ab_reg   <= 29'(it_reg[DivSteps].a) + 29'(it_reg[DivSteps].quo);
            cmag_reg <= cmag_next;
            lneg_reg <= lval[29];
        end
    end

    // stage Y: exponent, split into integer and fraction
    logic signed [31:0] ab_s;
    logic signed [31:0] cm_s;
    logic signed [31:0] y;
    logic signed [7:0]  n_reg;
    logic        [23:0] f_reg;

    assign ab_s = $signed({3'b000, ab_reg});
    assign cm_s = $signed({4'b0000, cmag_reg});
    assign y    = lneg_reg ? (ab_s + cm_s) : (ab_s - cm_s);

    always_ff @(posedge clk)
    begin
        if (en[StY])
        begin
            n_reg <= y[31:24];
            f_reg <= y[23:0];
        end
    end

    // stage X: series argument, series start at one
    ser_t ser_reg [2*SeriesTerms+1];
    ser_t ser_init;

    always_comb
    begin
        ser_init.x    = 30'((54'(f_reg) * 54'(Ln2Q30)) >> 24);
        ser_init.n    = n_reg;
        ser_init.term = 31'h4000_0000;
        ser_init.tx   = '0;
        ser_init.sum  = 32'h4000_0000;
    end

    always_ff @(posedge clk)
    begin
        if (en[StX])
            ser_reg[0] <= ser_init;
    end

    // series terms: multiply by x, then divide by k through a reciprocal
    for (genvar k = 0; k < SeriesTerms; k++)
    begin : g_term
        localparam int K     = k + 1;
        localparam int Lg    = $clog2(K);
        localparam int Shift = 31 + Lg;
        localparam logic [63:0] Recip = ((64'd1 << Shift) + 64'(K) - 64'd1) / 64'(K);
        ser_t        mul_next;
        ser_t        div_next;
        logic [30:0] term_q;

        always_comb
        begin
            mul_next    = ser_reg[2*k];
            mul_next.tx = 31'((61'(ser_reg[2*k].term) * 61'(ser_reg[2*k].x)) >> 30);
        end

        assign term_q = 31'((64'(ser_reg[2*k+1].tx) * 64'(Recip[32:0])) >> Shift);

        always_comb
        begin
            div_next      = ser_reg[2*k+1];
            div_next.term = term_q;
            div_next.sum  = ser_reg[2*k+1].sum + 32'(term_q);
        end

        always_ff @(posedge clk)
        begin
            if (en[StSer+2*k])
                ser_reg[2*k+1] <= mul_next;
            if (en[StSer+2*k+1])
                ser_reg[2*k+2] <= div_next;
        end
    end

    // stage P: scale by C1
    logic [63:0]       prod_reg;
    logic signed [7:0] np_reg;

    always_ff @(posedge clk)
    begin
        if (en[StP])
        begin
            prod_reg <= 64'(cfg.scale) * 64'(ser_reg[2*SeriesTerms].sum);
            np_reg   <= ser_reg[2*SeriesTerms].n;
        end
    end

    // stage S: shift into Q4.28 with saturation
    logic signed [8:0] sh;
    logic        [8:0] ls;
    logic       [63:0] shr;
    logic       [31:0] mu_next;
    logic       [31:0] mu_reg;

    assign sh = 9'sd30 - 9'(np_reg);
    assign ls = 9'(-sh);

    always_comb
    begin
        shr = prod_reg >> sh[5:0];
        if (sh >= 9'sd64)
            mu_next = '0;
        else if (sh >= 9'sd0)
            mu_next = (shr[63:32] != 32'd0) ? AllOnes : shr[31:0];
        else if (prod_reg == 64'd0)
            mu_next = '0;
        else if (ls > 9'd32 || prod_reg > (64'(AllOnes) >> ls[5:0]))
            mu_next = AllOnes;
        else
            mu_next = 32'(prod_reg << ls[5:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en[StS])
            mu_reg <= mu_next;
    end

    // stage O: clamp, floor wins over ceiling
    logic [31:0] capped;
    logic [31:0] visc_reg;

    assign capped = (mu_reg > cfg.vceil) ? cfg.vceil : mu_reg;

    always_ff @(posedge clk)
    begin
        if (en[StO])
            visc_reg <= (capped < cfg.vfloor) ? cfg.vfloor : capped;
    end

    assign viscosity = visc_reg;

endmodule

// ===== src/blood_viscosity_law_top.sv =====
// Blood viscosity law top level: handshake control, registers, assertions.
//
// Usage: each input word (volume_fraction Q2.16 signed, shear_rate Q16.16)
// gives one result word (viscosity Q4.28) on the output channel, in order.
// Both channels move a word on a clock edge where valid and ready are high.
// The datapath is a 60-stage pipeline; a result is offered once its word has
// passed every stage register; one word can enter on every clock unless a
// receiver stall has filled the pipeline. Depth is set by the 28
// restoring-divide steps (run beside the 24 log2 squaring steps) and the
// 12-term exp2 series, each term a multiply and a reciprocal-divide stage.
// When the receiver stalls, stages with data hold and empty stages keep
// filling, so input stays ready until every stage holds a word.
// The user must write registers through cfg_we/cfg_index/cfg_data only while
// the pipeline is empty; the block does not enforce it. Reset empties the
// pipeline and loads the registers with their default coefficients and limits.
module blood_viscosity_law_top (
    input  logic                   clk,
    input  logic                   rst_n,
    bvl_in_if.sink                 in_ch,
    bvl_out_if.source              out_ch,
    input  logic                   cfg_we,
    input  bvl_pkg::cfg_index_t    cfg_index,
    input  logic [31:0]            cfg_data
);
    import bvl_pkg::*;

    logic [NumStages-1:0] valid_reg;
    logic [NumStages-1:0] valid_next;
    logic [NumStages-1:0] stage_en;
    cfg_t                 cfg_reg;

    // stage enables: a stage loads when empty or when its successor moves
    assign stage_en[NumStages-1] = !valid_reg[NumStages-1] || out_ch.ready;
    for (genvar i = 0; i < NumStages - 1; i++)
    begin : g_en
        assign stage_en[i] = !valid_reg[i] || stage_en[i+1];
    end

    assign valid_next = {valid_reg[NumStages-2:0], in_ch.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= (valid_next & stage_en) | (valid_reg & ~stage_en);
    end

    assign in_ch.ready  = stage_en[0];
    assign out_ch.valid = valid_reg[NumStages-1];

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale   <= 32'd2139431;
            cfg_reg.protein <= 24'd1697382;
            cfg_reg.vfloor  <= 32'd268435;
            cfg_reg.vceil   <= 32'd268435456;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCALE:   cfg_reg.scale   <= cfg_data;
                REG_PROTEIN: cfg_reg.protein <= cfg_data[23:0];
                REG_FLOOR:   cfg_reg.vfloor  <= cfg_data;
                REG_CEILING: cfg_reg.vceil   <= cfg_data;
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

    bvl_datapath u_datapath (
        .clk             (clk),
        .en              (stage_en),
        .cfg             (cfg_reg),
        .volume_fraction (in_ch.volume_fraction),
        .shear_rate      (in_ch.shear_rate),
        .viscosity       (out_ch.viscosity)
    );

`ifndef SYNTH
    // result never below the floor, never above the ceiling when limits are ordered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.viscosity >= cfg_reg.vfloor) &&
                         ((cfg_reg.vfloor > cfg_reg.vceil) ||
                          (out_ch.viscosity <= cfg_reg.vceil)))
        else $error("viscosity outside limits");

    // an accepted word lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> valid_reg[0])
        else $error("accepted word lost at pipeline entry");

    // a full pipeline facing a stall must refuse input
    assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !out_ch.ready |-> !in_ch.ready)
        else $error("input taken while pipeline full");
`endif

endmodule

// ===== tb/blood_viscosity_law_top_test.sv =====
// Testbench for the blood viscosity pipeline: directed and random words, checked in order.
module blood_viscosity_law_top_test;
    import bvl_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    cfg_index_t cfg_index = REG_SCALE;
    logic [31:0] cfg_data = '0;

    bvl_in_if in_ch ();
    bvl_out_if out_ch ();

    blood_viscosity_law_top dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // model copy of the register file
    logic [31:0] coef_c1;
    logic [23:0] tpma;
    logic [31:0] visc_lo;
    logic [31:0] visc_hi;

    logic [31:0] visc_due[$];
    int mismatches = 0;
    bit rx_calm = 1'b0;
    bit tx_calm = 1'b0;

    initial in_ch.valid = 1'b0;
    initial in_ch.volume_fraction = '0;
    initial in_ch.shear_rate = '0;
    initial out_ch.ready = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // log2 of rate, signed Q.24
    function automatic longint log2_rate(logic [31:0] r);
        int p;
        logic [63:0] m;
        longint fr;
        p = 31;
        fr = 0;
        while (p > 0 && r[p] == 1'b0)
            p--;
        m = 64'(r) << (31 - p);
        for (int i = 0; i < 24; i++)
        begin
            m = (m * m) >> 31;
            fr = fr << 1;
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                fr = fr | 1;
            end
        end
        return longint'(p - 16) * (longint'(1) << 24) + fr;
    endfunction

    // viscosity for one cell under the current registers
    function automatic logic [31:0] viscosity_of(logic signed [17:0] vf, logic [31:0] rate_in);
        int fr;
        logic [31:0] rt;
        logic [63:0] h, h2, a, b, g, cm, yo, f, x, sum, term, prod, mu;
        longint l, c, y, n, s;
        fr = vf;
        rt = rate_in;
        if (fr < 16384) fr = 16384;
        if (fr > 65536) fr = 65536;
        if (rt == 0) rt = 1;
        h = 64'(fr) * 100;
        h2 = (h * h) >> 16;
        a = (64'(KaQ32) * h) >> 24;
        b = (64'(KbQ24) * 64'(tpma)) / h2;
        l = log2_rate(rt);
        g = (64'(KcQ32) * h) >> 24;
        cm = (g * 64'(l < 0 ? -l : l)) >> 24;
        c = l < 0 ? -longint'(cm) : longint'(cm);
        y = longint'(a) + longint'(b) - c;
        yo = 64'(y + (longint'(64) << 24));
        n = longint'(yo >> 24) - 64;
        f = yo & 64'hFF_FFFF;
        // 2^f by series
        x = (f * 64'(Ln2Q30)) >> 24;
        sum = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * x) >> 30) / k;
            sum += term;
        end
        prod = 64'(coef_c1) * sum;
        s = 30 - n;
        if (s >= 64) mu = 0;
        else if (s >= 0) mu = prod >> s;
        else if (prod == 0) mu = 0;
        else if (-s > 32 || prod > (64'(AllOnes) >> (-s))) mu = 64'(AllOnes);
        else mu = prod << (-s);
        if (mu > 64'(AllOnes)) mu = 64'(AllOnes);
        if (mu > 64'(visc_hi)) mu = 64'(visc_hi);
        if (mu < 64'(visc_lo)) mu = 64'(visc_lo);
        return mu[31:0];
    endfunction

    task automatic idle_cycles(int k);
        repeat (k) @(posedge clk);
    endtask

    // one register write; write enable is low again before the task returns
    task automatic write_reg(cfg_index_t idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SCALE: coef_c1 = val;
            REG_PROTEIN: tpma = val[23:0];
            REG_FLOOR: visc_lo = val;
            default: visc_hi = val;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (visc_due.size() != 0)
            @(posedge clk);
        idle_cycles(4);
    endtask

    // send one word, with random gaps; valid stays high for a following word
    task automatic send_cell(logic signed [17:0] vf, logic [31:0] rate);
        while (!tx_calm && $urandom_range(99) < 26)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.volume_fraction <= vf;
        in_ch.shear_rate <= rate;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        visc_due.push_back(viscosity_of(vf, rate));
    endtask

    // receiver stalls
    always @(posedge clk)
        out_ch.ready <= rst_n && (rx_calm || $urandom_range(99) >= 26);

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (visc_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected viscosity word %h", out_ch.viscosity);
            end
            else
            begin
                logic [31:0] want;
                want = visc_due.pop_front();
                if (out_ch.viscosity !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("viscosity: expected %h actual %h", want, out_ch.viscosity);
                end
            end
        end
    end

    function automatic logic [31:0] random_rate();
        case ($urandom_range(4))
            0: return $urandom_range(3);
            1: return 32'h1_0000 + $urandom_range(255) - 128;
            2: return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [17:0] random_fraction();
        if ($urandom_range(3) == 0)
            return 18'($urandom);
        return 18'($urandom_range(65536 + 200, 16384 - 200));
    endfunction

    task automatic test_field_extremes();
        send_cell(18'sh1FFFF, 32'hFFFF_FFFF);
        send_cell(18'sh20000, 32'd0);
        send_cell(18'sd16384, 32'd1);
        send_cell(18'sd65536, 32'h1_0000);
        send_cell(18'sd16383, 32'h8000_0000);
        send_cell(18'sd65537, 32'd2);
        send_cell(-18'sd1, 32'h0000_8000);
        send_cell(18'sd0, 32'h2_0000);
        send_cell(18'sd40000, 32'h0001_0001);
        send_cell(18'sh2AAAA, 32'hAAAA_AAAA);
        send_cell(18'sh15555, 32'h5555_5555);
        wait_drained();
    endtask

    task automatic test_saturation();
        // product overflow and underflow, floor above ceiling
        write_reg(REG_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_PROTEIN, 32'h00FF_FFFF);
        write_reg(REG_FLOOR, 32'd0);
        write_reg(REG_CEILING, 32'hFFFF_FFFF);
        send_cell(18'sd16384, 32'd0);
        send_cell(18'sd65536, 32'hFFFF_FFFF);
        wait_drained();
        write_reg(REG_SCALE, 32'd0);
        send_cell(18'sd30000, 32'd5);
        wait_drained();
        write_reg(REG_SCALE, 32'd1);
        write_reg(REG_PROTEIN, 32'd0);
        send_cell(18'sd65536, 32'hFFFF_FFFF);
        wait_drained();
        write_reg(REG_SCALE, 32'h1000_0000);
        write_reg(REG_FLOOR, 32'h8000_0000);
        write_reg(REG_CEILING, 32'h0000_1000);
        send_cell(18'sd50000, 32'h1_0000);
        send_cell(18'sd16384, 32'd1);
        wait_drained();
    endtask

    task automatic test_random_phase(int count);
        write_reg(REG_SCALE, $urandom);
        write_reg(REG_PROTEIN, {8'd0, 24'($urandom)});
        write_reg(REG_FLOOR, $urandom_range(32'h0010_0000));
        write_reg(REG_CEILING, $urandom_range(32'hFFFF_FFFF, 32'h0100_0000));
        for (int i = 0; i < count; i++)
            send_cell(random_fraction(), random_rate());
        wait_drained();
    endtask

    task automatic test_back_to_back();
        // full rate on both sides
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        for (int i = 0; i < 200; i++)
            send_cell(random_fraction(), random_rate());
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        coef_c1 = 32'd2139431;
        tpma = 24'd1697382;
        visc_lo = 32'd268435;
        visc_hi = 32'd268435456;
        idle_cycles(10);
        rst_n <= 1'b1;
        idle_cycles(2);
        test_field_extremes();
        test_saturation();
        write_reg(REG_SCALE, 32'd2139431);
        write_reg(REG_PROTEIN, 32'd1697382);
        write_reg(REG_FLOOR, 32'd268435);
        write_reg(REG_CEILING, 32'd268435456);
        test_back_to_back();
        for (int ph = 0; ph < 5; ph++)
            test_random_phase(246);
        wait_drained();
        idle_cycles(70);
        if (mismatches == 0 && visc_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
